@@ design/svbg_pkg.sv @@
package svbg_pkg;

	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned SET_W   = 8;
	localparam int unsigned GAIN_W  = 32;
	localparam int unsigned RANGE_W = 7;
	localparam int unsigned PROD_W  = 2 * LEVEL_W;
	localparam int unsigned CIDX_W  = 2;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);
	localparam logic [LEVEL_W-1:0] LEVEL_STEP = LEVEL_W'(5);

	// floor(x / 100) == (x * 5243) >> 19 for every x below 43699
	localparam int unsigned        RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100   = RECIP_W'(5243);
	localparam int unsigned        RECIP_SHIFT = 19;
	localparam int unsigned        QPROD_W     = PROD_W + RECIP_W;

	typedef enum logic [1:0] {
		MODE_SET  = 2'd0,
		MODE_MUTE = 2'd1,
		MODE_UP   = 2'd2,
		MODE_DOWN = 2'd3
	} mode_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_RANGE     = 2'd0,
		REG_GAIN_MIN  = 2'd1,
		REG_GAIN_MAX  = 2'd2,
		REG_CLAMP_EN  = 2'd3
	} reg_idx_t;

	localparam logic [RANGE_W-1:0] RANGE_RESET    = RANGE_W'(100);
	localparam logic [GAIN_W-1:0]  GAIN_MIN_RESET = 32'h0000_0000;
	localparam logic [GAIN_W-1:0]  GAIN_MAX_RESET = 32'h7fff_ffff;

	// Full scale times 2^(-k/4), about 0, 1.5, 3 and 4.5 dB below full scale, fractions cut off
	localparam logic [GAIN_W-1:0] GAIN_TABLE [4] = '{
		32'h7fff_ffff,
		32'd1805811300,
		32'd1518500249,
		32'd1276901416
	};

endpackage

@@ design/svbg_ifs.sv @@
interface svbg_evt_if;
	logic                               valid;
	logic                               ready;
	svbg_pkg::mode_t                    mode;
	logic [svbg_pkg::SET_W-1:0]         set_left;
	logic [svbg_pkg::SET_W-1:0]         set_right;

	modport source (output valid, mode, set_left, set_right, input ready);
	modport sink   (input valid, mode, set_left, set_right, output ready);
endinterface

interface svbg_res_if;
	logic                               valid;
	logic                               ready;
	logic [svbg_pkg::LEVEL_W-1:0]       left_level;
	logic [svbg_pkg::LEVEL_W-1:0]       right_level;
	logic signed [svbg_pkg::GAIN_W-1:0] left_gain;
	logic signed [svbg_pkg::GAIN_W-1:0] right_gain;
	logic                               mute_held;

	modport source (output valid, left_level, right_level, left_gain, right_gain, mute_held,
		input ready);
	modport sink   (input valid, left_level, right_level, left_gain, right_gain, mute_held,
		output ready);
endinterface

interface svbg_cfg_if;
	logic                               valid;
	logic                               ready;
	svbg_pkg::reg_idx_t                 index;
	logic [svbg_pkg::GAIN_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ design/stereo_volume_button_gain.sv @@
// Stereo volume block driven by button events (set, mute toggle, up, down). Each accepted
// event word on evt gives exactly one result word on res with both levels, both linear
// gains and the mute flag. One event can be accepted every clock cycle unless res stalls.
// The four-stage datapath (level update, 100 minus level times range, divide by 100 by
// reciprocal multiply, table lookup with shift and clamp) moves as one: while a finished
// result waits on res, every stage holds and evt.ready is low. Registers on cfg are always
// taken at once and should be written only while no event is in flight.
module stereo_volume_button_gain (
	input  logic       clk,
	input  logic       arst_n,
	svbg_evt_if.sink   evt,
	svbg_res_if.source res,
	svbg_cfg_if.sink   cfg
);

	localparam int unsigned LW = svbg_pkg::LEVEL_W;
	localparam int unsigned PW = svbg_pkg::PROD_W;
	localparam int unsigned GW = svbg_pkg::GAIN_W;

	// configuration
	logic [svbg_pkg::RANGE_W-1:0] range_q;
	logic signed [GW-1:0]         gain_min_q;
	logic signed [GW-1:0]         gain_max_q;
	logic                         clamp_en_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q    <= svbg_pkg::RANGE_RESET;
			gain_min_q <= svbg_pkg::GAIN_MIN_RESET;
			gain_max_q <= svbg_pkg::GAIN_MAX_RESET;
			clamp_en_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				svbg_pkg::REG_RANGE:    range_q    <= cfg.data[svbg_pkg::RANGE_W-1:0];
				svbg_pkg::REG_GAIN_MIN: gain_min_q <= cfg.data;
				svbg_pkg::REG_GAIN_MAX: gain_max_q <= cfg.data;
				svbg_pkg::REG_CLAMP_EN: clamp_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// pipeline advance: all stages move together unless the result word is stalled
	logic advance;
	logic accept;

	assign advance   = !res.valid || res.ready;
	assign evt.ready = advance;
	assign accept    = evt.valid && advance;

	// level state
	logic [LW-1:0]  left_q, right_q;
	logic [15:0]    saved_q;
	logic [LW-1:0]  left_d, right_d;
	logic [15:0]    saved_d;
	logic [LW-1:0]  left_rest, right_rest;

	function automatic logic [LW-1:0] sat_set(input logic [svbg_pkg::SET_W-1:0] v);
		sat_set = (v > svbg_pkg::SET_W'(svbg_pkg::LEVEL_FULL)) ?
			svbg_pkg::LEVEL_FULL : v[LW-1:0];
	endfunction

	function automatic logic [LW-1:0] step_up(input logic [LW-1:0] v);
		logic [LW:0] s;
		s = {1'b0, v} + {1'b0, svbg_pkg::LEVEL_STEP};
		step_up = (s > {1'b0, svbg_pkg::LEVEL_FULL}) ? svbg_pkg::LEVEL_FULL : s[LW-1:0];
	endfunction

	function automatic logic [LW-1:0] step_down(input logic [LW-1:0] v);
		step_down = (v < svbg_pkg::LEVEL_STEP) ? '0 : v - svbg_pkg::LEVEL_STEP;
	endfunction

	assign left_rest  = sat_set(saved_q[7:0]);
	assign right_rest = sat_set(saved_q[15:8]);

	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		saved_d = saved_q;
		case (evt.mode)
			svbg_pkg::MODE_SET: begin
				left_d  = sat_set(evt.set_left);
				right_d = sat_set(evt.set_right);
			end
			svbg_pkg::MODE_MUTE: begin
				if (saved_q != 16'd0) begin
					left_d  = left_rest;
					right_d = right_rest;
					saved_d = 16'd0;
				end else begin
					saved_d = {1'b0, right_q, 1'b0, left_q};
					left_d  = '0;
					right_d = '0;
				end
			end
			svbg_pkg::MODE_UP: begin
				left_d  = step_up(left_q);
				right_d = step_up(right_q);
			end
			svbg_pkg::MODE_DOWN: begin
				left_d  = step_down(left_q);
				right_d = step_down(right_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
			saved_q <= '0;
		end else if (accept) begin
			left_q  <= left_d;
			right_q <= right_d;
			saved_q <= saved_d;
		end
	end

	// stage valids
	logic valid_s1, valid_s2, valid_s3, res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	// payload stages
	logic [LW-1:0]                  left_s1, right_s1, left_s2, right_s2, left_s3, right_s3;
	logic                           held_s1, held_s2, held_s3;
	logic [PW-1:0]                  lprod_s2, rprod_s2;
	logic [svbg_pkg::RANGE_W-1:0]   latt_s3, ratt_s3;
	logic [svbg_pkg::QPROD_W-1:0]   lq, rq;

	assign lq = svbg_pkg::QPROD_W'(lprod_s2) * svbg_pkg::QPROD_W'(svbg_pkg::RECIP_100);
	assign rq = svbg_pkg::QPROD_W'(rprod_s2) * svbg_pkg::QPROD_W'(svbg_pkg::RECIP_100);

	function automatic logic signed [GW-1:0] gain_of(input logic [svbg_pkg::RANGE_W-1:0] a,
		input logic [svbg_pkg::RANGE_W-1:0] rng, input logic en,
		input logic signed [GW-1:0] gmin, input logic signed [GW-1:0] gmax);
		logic signed [GW-1:0] g;
		g = (a >= rng) ? '0 : $signed(svbg_pkg::GAIN_TABLE[a[1:0]] >> a[6:2]);
		if (en) begin
			if (g > gmax)
				g = gmax;
			else if (g < gmin)
				g = gmin;
		end
		gain_of = g;
	endfunction

	logic [LW-1:0]        res_left_q, res_right_q;
	logic signed [GW-1:0] res_lgain_q, res_rgain_q;
	logic                 res_held_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s1  <= left_d;
			right_s1 <= right_d;
			held_s1  <= (saved_d != 16'd0);

			left_s2  <= left_s1;
			right_s2 <= right_s1;
			held_s2  <= held_s1;
			lprod_s2 <= PW'(svbg_pkg::LEVEL_FULL - left_s1) * PW'(range_q);
			rprod_s2 <= PW'(svbg_pkg::LEVEL_FULL - right_s1) * PW'(range_q);

			left_s3  <= left_s2;
			right_s3 <= right_s2;
			held_s3  <= held_s2;
			latt_s3  <= lq[svbg_pkg::RECIP_SHIFT +: svbg_pkg::RANGE_W];
			ratt_s3  <= rq[svbg_pkg::RECIP_SHIFT +: svbg_pkg::RANGE_W];

			res_left_q  <= left_s3;
			res_right_q <= right_s3;
			res_held_q  <= held_s3;
			res_lgain_q <= gain_of(latt_s3, range_q, clamp_en_q, gain_min_q, gain_max_q);
			res_rgain_q <= gain_of(ratt_s3, range_q, clamp_en_q, gain_min_q, gain_max_q);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.left_level  = res_left_q;
	assign res.right_level = res_right_q;
	assign res.left_gain   = res_lgain_q;
	assign res.right_gain  = res_rgain_q;
	assign res.mute_held   = res_held_q;

endmodule
